@@ src/keyed_lifo_remove_store_macros.svh @@
// ---------------------------------------------------------------------------
// Keyed LIFO store assertion macros
// Shared property wrappers for the checker of the keyed LIFO store. They
// expect signals named clock and reset in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef KEYED_LIFO_REMOVE_STORE_MACROS_SVH
`define KEYED_LIFO_REMOVE_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KLRS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KLRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/klrs_pkg.sv @@
// ---------------------------------------------------------------------------
// Keyed LIFO store package
// Sizes, operation and status codes, and the types shared between the
// sequencer, the entry memory and the checker.
// ---------------------------------------------------------------------------
package klrs_pkg;

   // Store geometry.
   localparam int DEPTH         = 64;
   localparam int KEY_WIDTH     = 64;
   localparam int PAYLOAD_WIDTH = 64;
   localparam int FIELD_WIDTH   = 64;
   localparam int OCC_WIDTH     = 7;
   localparam int IDX_WIDTH     = $clog2(DEPTH);
   localparam int CNT_WIDTH     = $clog2(DEPTH + 1);

   typedef logic [IDX_WIDTH-1:0]   idx_type;
   typedef logic [CNT_WIDTH-1:0]   cnt_type;
   typedef logic [OCC_WIDTH-1:0]   occ_type;
   typedef logic [FIELD_WIDTH-1:0] field_type;

   // Operation codes.
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   // One stored entry.
   typedef struct packed {
      logic [KEY_WIDTH-1:0]     key;
      logic [PAYLOAD_WIDTH-1:0] payload;
   } entry_type;

   // Access request from the sequencer to the entry memory.
   typedef struct packed {
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
      logic      rd_en;
      idx_type   rd_addr;
   } mem_req_type;

endpackage

@@ src/klrs_mem.sv @@
// ---------------------------------------------------------------------------
// Keyed LIFO store entry memory
// Single-port-write, single-port-read synchronous memory holding the key and
// payload of every entry. Read data is registered, ready the cycle after the request.
// ---------------------------------------------------------------------------
module klrs_mem (
   input  logic                  clock,
   input  klrs_pkg::mem_req_type mem_req,
   output klrs_pkg::entry_type   rd_data
);

   klrs_pkg::entry_type mem_ff [klrs_pkg::DEPTH];
   klrs_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/klrs_ctrl.sv @@
// ---------------------------------------------------------------------------
// Keyed LIFO store sequencer
// Runs push, pop and clear against the entry memory. A pop walks the memory
// from the newest entry downwards, one read per cycle, then shifts the newer
// entries down one place to close the gap, again one entry per cycle.
// ---------------------------------------------------------------------------
module klrs_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_opcode,
   input  logic [klrs_pkg::FIELD_WIDTH-1:0] req_entry_key,
   input  logic [klrs_pkg::FIELD_WIDTH-1:0] req_entry_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [klrs_pkg::FIELD_WIDTH-1:0] rsp_found_key,
   output logic [klrs_pkg::FIELD_WIDTH-1:0] rsp_found_payload,
   output logic [klrs_pkg::OCC_WIDTH-1:0]   rsp_occupancy,
   output klrs_pkg::mem_req_type            mem_req,
   input  klrs_pkg::entry_type              rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   state_type                            state_ff, state_in;
   klrs_pkg::cnt_type                    count_ff, count_in;
   klrs_pkg::cnt_type                    addr_ff, addr_in;
   logic                                 issue_ff, issue_in;
   logic                                 pend_ff, pend_in;
   klrs_pkg::idx_type                    pend_addr_ff, pend_addr_in;
   logic [klrs_pkg::KEY_WIDTH-1:0]       key_ff, key_in;
   logic [1:0]                           res_status_ff, res_status_in;
   logic [klrs_pkg::KEY_WIDTH-1:0]       res_key_ff, res_key_in;
   logic [klrs_pkg::PAYLOAD_WIDTH-1:0]   res_payload_ff, res_payload_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]                           rsp_status_ff, rsp_status_in;
   logic [klrs_pkg::FIELD_WIDTH-1:0]     rsp_key_ff, rsp_key_in;
   logic [klrs_pkg::FIELD_WIDTH-1:0]     rsp_payload_ff, rsp_payload_in;
   klrs_pkg::occ_type                    rsp_occ_ff, rsp_occ_in;
   logic                                 key_hit;
   klrs_pkg::cnt_type                    pend_next;

   // A zero request key matches any entry.
   assign key_hit   = (key_ff == '0) || (rd_data.key == key_ff);
   assign pend_next = klrs_pkg::cnt_type'(pend_addr_ff) + klrs_pkg::cnt_type'(1);

   // Next-state and memory request logic.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      addr_in        = addr_ff;
      issue_in       = issue_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      key_in         = key_ff;
      res_status_in  = res_status_ff;
      res_key_in     = res_key_ff;
      res_payload_in = res_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_occ_in     = rsp_occ_ff;

      mem_req         = '0;
      mem_req.rd_addr = addr_ff[klrs_pkg::IDX_WIDTH-1:0];
      mem_req.wr_addr = count_ff[klrs_pkg::IDX_WIDTH-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in         = req_entry_key;
               res_status_in  = klrs_pkg::ST_OK;
               res_key_in     = '0;
               res_payload_in = '0;
               state_in       = S_DONE;
               case (req_opcode)
                  klrs_pkg::OP_PUSH: begin
                     if (count_ff >= klrs_pkg::cnt_type'(klrs_pkg::DEPTH)) begin
                        res_status_in = klrs_pkg::ST_FULL;
                     end else begin
                        mem_req.wr_en           = 1'b1;
                        mem_req.wr_data.key     = req_entry_key;
                        mem_req.wr_data.payload =
                           req_entry_payload[klrs_pkg::PAYLOAD_WIDTH-1:0];
                        count_in = count_ff + klrs_pkg::cnt_type'(1);
                     end
                  end
                  klrs_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        res_status_in = klrs_pkg::ST_NOMATCH;
                     end else begin
                        addr_in  = count_ff - klrs_pkg::cnt_type'(1);
                        issue_in = 1'b1;
                        pend_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  klrs_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // Unused code: report success and leave the store alone.
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Issue the next read from the newest entry downwards.
            mem_req.rd_en = issue_ff;
            pend_in       = issue_ff;
            pend_addr_in  = addr_ff[klrs_pkg::IDX_WIDTH-1:0];
            if (issue_ff) begin
               if (addr_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff - klrs_pkg::cnt_type'(1);
               end
            end
            // Check the entry read in the previous cycle.
            if (pend_ff && key_hit) begin
               res_key_in     = rd_data.key;
               res_payload_in = rd_data.payload;
               addr_in        = pend_next;
               issue_in       = (pend_next < count_ff);
               pend_in        = 1'b0;
               state_in       = S_SHIFT;
            end else if (pend_ff && (pend_addr_ff == '0)) begin
               res_status_in = klrs_pkg::ST_NOMATCH;
               issue_in      = 1'b0;
               pend_in       = 1'b0;
               state_in      = S_DONE;
            end
         end

         S_SHIFT: begin
            // Read entry r+1 and write it back one place lower in the next cycle.
            mem_req.rd_en = issue_ff;
            pend_in       = issue_ff;
            pend_addr_in  = addr_ff[klrs_pkg::IDX_WIDTH-1:0];
            if (issue_ff) begin
               addr_in  = addr_ff + klrs_pkg::cnt_type'(1);
               issue_in = ((addr_ff + klrs_pkg::cnt_type'(1)) < count_ff);
            end
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pend_addr_ff - klrs_pkg::idx_type'(1);
               mem_req.wr_data = rd_data;
            end
            if (!issue_ff && !pend_ff) begin
               count_in = count_ff - klrs_pkg::cnt_type'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_key_in     = klrs_pkg::field_type'(res_key_ff);
               rsp_payload_in = klrs_pkg::field_type'(res_payload_ff);
               rsp_occ_in     = klrs_pkg::occ_type'(count_ff);
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff        <= addr_in;
      pend_addr_ff   <= pend_addr_in;
      key_ff         <= key_in;
      res_status_ff  <= res_status_in;
      res_key_ff     <= res_key_in;
      res_payload_ff <= res_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_key     = rsp_key_ff;
   assign rsp_found_payload = rsp_payload_ff;
   assign rsp_occupancy     = rsp_occ_ff;

endmodule

@@ src/keyed_lifo_remove_store.sv @@
// The block takes one item at a time: a new item is accepted only once the
// result of the last one has moved into the output register. A pop scans and
// shifts one entry a cycle, set by the single read port. Reset clears the count
// and the control state; the stored entries are not cleared.
// ---------------------------------------------------------------------------
// Keyed LIFO store
// Bounded stack of keyed entries with removal of the newest entry that
// matches a key. Top level joining the sequencer and the entry memory.
// ---------------------------------------------------------------------------
module keyed_lifo_remove_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_opcode,
   input  logic [klrs_pkg::FIELD_WIDTH-1:0] req_entry_key,
   input  logic [klrs_pkg::FIELD_WIDTH-1:0] req_entry_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [klrs_pkg::FIELD_WIDTH-1:0] rsp_found_key,
   output logic [klrs_pkg::FIELD_WIDTH-1:0] rsp_found_payload,
   output logic [klrs_pkg::OCC_WIDTH-1:0]   rsp_occupancy
);

   klrs_pkg::mem_req_type mem_req;
   klrs_pkg::entry_type   rd_data;

   // Operation sequencer.
   klrs_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_entry_key     (req_entry_key),
      .req_entry_payload (req_entry_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_payload (rsp_found_payload),
      .rsp_occupancy     (rsp_occupancy),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

   // Entry memory.
   klrs_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

@@ src/klrs_checker.sv @@
// ---------------------------------------------------------------------------
// Keyed LIFO store port checker
// Watches the ports of the keyed LIFO store for handshake and result
// consistency, and is bound to every instance of the top level.
// ---------------------------------------------------------------------------
`include "keyed_lifo_remove_store_macros.svh"

module klrs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [1:0]                       rsp_status,
   input logic [klrs_pkg::FIELD_WIDTH-1:0] rsp_found_key,
   input logic [klrs_pkg::FIELD_WIDTH-1:0] rsp_found_payload,
   input logic [klrs_pkg::OCC_WIDTH-1:0]   rsp_occupancy
);

   logic                                     req_take;
   logic                                     rsp_stall;
   logic                                     rsp_fail;
   logic                                     rsp_full;
   logic                                     rsp_entry_zero;
   logic                                     occ_at_depth;
   logic [2*klrs_pkg::FIELD_WIDTH+klrs_pkg::OCC_WIDTH+1:0] rsp_bundle;

   // Conditions watched by the properties below.
   assign req_take       = req_valid && req_ready;
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_fail       = rsp_valid && (rsp_status != klrs_pkg::ST_OK);
   assign rsp_full       = rsp_valid && (rsp_status == klrs_pkg::ST_FULL);
   assign rsp_entry_zero = (rsp_found_key == '0) && (rsp_found_payload == '0);
   assign occ_at_depth   = (rsp_occupancy == klrs_pkg::occ_type'(klrs_pkg::DEPTH));
   assign rsp_bundle     = {rsp_status, rsp_found_key, rsp_found_payload, rsp_occupancy};

   // A stalled result holds its value.
   `KLRS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_bundle), "held result moved")

   // The block works on one item at a time.
   `KLRS_ASSERT_NEXT(a_busy_after_accept, req_take, !req_ready, "item accepted while busy")

   // A failed operation returns no entry.
   `KLRS_ASSERT_SAME(a_fail_zero, rsp_fail, rsp_entry_zero, "failed operation returned an entry")

   // A full report only comes from a full store.
   `KLRS_ASSERT_SAME(a_full_occ, rsp_full, occ_at_depth, "full reported below capacity")

endmodule

bind keyed_lifo_remove_store klrs_checker u_klrs_checker (.*);
